// ===== sv/four_channel_rms_accumulator_unit_defines.svh =====
// assertion macros used by the rms accumulator back end
`ifndef FOUR_CHANNEL_RMS_ACCUMULATOR_UNIT_DEFINES_SVH
`define FOUR_CHANNEL_RMS_ACCUMULATOR_UNIT_DEFINES_SVH

// property that must hold in the same cycle
`define FCRMS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequence checked in the cycle after the trigger
`define FCRMS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/fcrms_pkg.sv =====
`default_nettype none
package fcrms_pkg;
	localparam int FRAME_WORDS = 32;
	localparam int SAMPLE_BITS = 12;
	localparam int NUM_CH      = 4;
	localparam int MEAN_SHIFT  = 3;

	localparam int SAMPLE_W   = 12;
	localparam int IDX_W      = $clog2(FRAME_WORDS);
	localparam int CH_W       = $clog2(NUM_CH);
	localparam int SUM_W      = SAMPLE_BITS + $clog2(FRAME_WORDS / NUM_CH);
	localparam int MEAN_W     = SUM_W - MEAN_SHIFT;
	localparam int OFF_W      = 12;
	localparam int MAG_W      = (MEAN_W > OFF_W) ? MEAN_W : OFF_W;
	localparam int SQ_W       = 2 * MAG_W;
	localparam int ACC_W      = 32;
	localparam int PER_W      = 8;
	localparam int RMS_W      = 12;
	localparam int ROOT_W     = ACC_W / 2;
	localparam int SREM_W     = ROOT_W + 4;
	localparam int STEP_W     = $clog2(ACC_W);
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;
	localparam int QUEUE_DEPTH = 2;
	localparam int QP_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QC_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [PER_W-1:0] PERIOD_RESET = PER_W'(24);
	localparam logic [RMS_W-1:0] RMS_MAX      = {RMS_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_A = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_B = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_C = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_D = CFG_IDX_W'(4);

	typedef struct packed {
		logic                           skip;
		logic [NUM_CH-1:0][SUM_W-1:0]   sums;
	} frame_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	typedef struct packed {
		logic [CH_W-1:0]  channel;
		logic [ACC_W-1:0] square_sum;
		logic [RMS_W-1:0] rms_code;
		logic             frame_error;
		logic             last;
	} result_t;
endpackage
`default_nettype wire

// ===== sv/fcrms_front.sv =====
`default_nettype none
module fcrms_front (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [fcrms_pkg::SAMPLE_W-1:0]     sample,
	input  wire logic                               skip_frame,
	output logic                                    push,
	output fcrms_pkg::frame_t                       push_frame,
	input  wire fcrms_pkg::queue_stat_t             q_stat
);
	import fcrms_pkg::*;

	logic [IDX_W-1:0]             idx_q;
	logic [NUM_CH-1:0][SUM_W-1:0] sums_q;
	logic [NUM_CH-1:0][SUM_W-1:0] sums_next;
	logic [CH_W-1:0]              ch;
	logic                         last_word;
	logic                         accept;

	assign ch        = idx_q[CH_W-1:0];
	assign last_word = (idx_q == IDX_W'(FRAME_WORDS - 1));
	assign in_ready  = !(last_word && q_stat.full);
	assign accept    = in_valid && in_ready;

	always_comb begin
		sums_next     = sums_q;
		sums_next[ch] = sums_q[ch] + SUM_W'(sample[SAMPLE_BITS-1:0]);
	end

	assign push            = accept && last_word;
	assign push_frame.skip = skip_frame;
	assign push_frame.sums = sums_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			sums_q <= '0;
		end else if (accept) begin
			if (last_word) begin
				idx_q  <= '0;
				sums_q <= '0;
			end else begin
				idx_q  <= idx_q + 1'b1;
				sums_q <= sums_next;
			end
		end
	end
endmodule
`default_nettype wire

// ===== sv/fcrms_queue.sv =====
`default_nettype none
module fcrms_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire fcrms_pkg::frame_t  push_frame,
	input  wire logic               pop,
	output fcrms_pkg::frame_t       pop_frame,
	output fcrms_pkg::queue_stat_t  q_stat
);
	import fcrms_pkg::*;

	frame_t           mem_q [QUEUE_DEPTH];
	logic [QP_W-1:0]  wr_q;
	logic [QP_W-1:0]  rd_q;
	logic [QC_W-1:0]  cnt_q;

	assign q_stat.full  = (cnt_q == QC_W'(QUEUE_DEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign pop_frame    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ===== sv/fcrms_back.sv =====
`default_nettype none
`include "four_channel_rms_accumulator_unit_defines.svh"
module fcrms_back (
	input  wire logic                                              clk,
	input  wire logic                                              arst_n,
	input  wire fcrms_pkg::queue_stat_t                            q_stat,
	input  wire fcrms_pkg::frame_t                                 pop_frame,
	output logic                                                   pop,
	input  wire logic [fcrms_pkg::PER_W-1:0]                       period,
	input  wire logic [fcrms_pkg::NUM_CH-1:0][fcrms_pkg::OFF_W-1:0] offsets,
	output logic                                                   out_valid,
	input  wire logic                                              out_ready,
	output fcrms_pkg::result_t                                     out_result
);
	import fcrms_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MAG  = 4'd1;
	localparam logic [3:0] ST_SQR  = 4'd2;
	localparam logic [3:0] ST_ACC  = 4'd3;
	localparam logic [3:0] ST_FCNT = 4'd4;
	localparam logic [3:0] ST_LOAD = 4'd5;
	localparam logic [3:0] ST_DIV  = 4'd6;
	localparam logic [3:0] ST_SQRT = 4'd7;
	localparam logic [3:0] ST_OUT  = 4'd8;
	localparam logic [3:0] ST_ERR  = 4'd9;

	logic [3:0]        state_q;
	frame_t            frame_q;
	logic [CH_W-1:0]   ch_q;
	logic [MAG_W-1:0]  mag_q;
	logic [SQ_W-1:0]   sq_q;
	logic [ACC_W-1:0]  acc_q [NUM_CH];
	logic [PER_W-1:0]  fcnt_q;
	logic [PER_W-1:0]  div_q;
	logic [STEP_W-1:0] step_q;
	logic [PER_W-1:0]  rem_q;
	logic [ACC_W-1:0]  val_q;
	logic [SREM_W-1:0] srem_q;
	logic [ROOT_W-1:0] root_q;
	logic              out_valid_q;
	result_t           out_q;

	logic [MEAN_W-1:0] mean;
	logic [MAG_W:0]    dif;
	logic [MAG_W:0]    dif_neg;
	logic [MAG_W-1:0]  mag;
	logic [PER_W-1:0]  per_eff;
	logic [PER_W-1:0]  cnt_inc;
	logic [PER_W:0]    dt;
	logic [PER_W:0]    dt_sub;
	logic              dge;
	logic [SREM_W-1:0] sr;
	logic [SREM_W-1:0] trial;
	logic              sge;
	logic [RMS_W-1:0]  rms_sat;
	logic              out_free;
	logic              ch_last;

	// offset-corrected frame mean magnitude
	assign mean    = frame_q.sums[ch_q][SUM_W-1:MEAN_SHIFT];
	assign dif     = {1'b0, MAG_W'(mean)} - {1'b0, MAG_W'(offsets[ch_q])};
	assign dif_neg = -dif;
	assign mag     = dif[MAG_W] ? dif_neg[MAG_W-1:0] : dif[MAG_W-1:0];

	assign per_eff = (period == '0) ? PER_W'(1) : period;
	assign cnt_inc = fcnt_q + 1'b1;
	assign ch_last = (ch_q == CH_W'(NUM_CH - 1));

	// restoring divide, one quotient bit per step
	assign dt     = {rem_q, val_q[ACC_W-1]};
	assign dge    = (dt >= {1'b0, div_q});
	assign dt_sub = dt - {1'b0, div_q};

	// digit-by-digit root, one root bit per step
	assign sr    = {srem_q[SREM_W-3:0], val_q[ACC_W-1:ACC_W-2]};
	assign trial = SREM_W'({root_q, 2'b01});
	assign sge   = (sr >= trial);

	assign rms_sat  = (root_q > ROOT_W'(RMS_MAX)) ? RMS_MAX : root_q[RMS_W-1:0];
	assign out_free = !out_valid_q || out_ready;
	assign pop      = (state_q == ST_IDLE) && !q_stat.empty;

	assign out_valid  = out_valid_q;
	assign out_result = out_q;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop) begin
					frame_q <= pop_frame;
				end
			end
			ST_MAG: begin
				mag_q <= mag;
			end
			ST_SQR: begin
				sq_q <= SQ_W'(mag_q) * SQ_W'(mag_q);
			end
			ST_LOAD: begin
				val_q <= acc_q[ch_q];
				rem_q <= '0;
			end
			ST_DIV: begin
				rem_q <= dge ? dt_sub[PER_W-1:0] : dt[PER_W-1:0];
				val_q <= {val_q[ACC_W-2:0], dge};
				if (step_q == STEP_W'(ACC_W - 1)) begin
					srem_q <= '0;
					root_q <= '0;
				end
			end
			ST_SQRT: begin
				srem_q <= sge ? (sr - trial) : sr;
				root_q <= {root_q[ROOT_W-2:0], sge};
				val_q  <= {val_q[ACC_W-3:0], 2'b00};
			end
			ST_OUT: begin
				if (out_free) begin
					out_q.channel     <= ch_q;
					out_q.square_sum  <= acc_q[ch_q];
					out_q.rms_code    <= rms_sat;
					out_q.frame_error <= 1'b0;
					out_q.last        <= ch_last;
				end
			end
			ST_ERR: begin
				if (out_free) begin
					out_q.channel     <= '0;
					out_q.square_sum  <= '0;
					out_q.rms_code    <= '0;
					out_q.frame_error <= 1'b1;
					out_q.last        <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= '0;
			fcnt_q      <= '0;
			div_q       <= PER_W'(1);
			step_q      <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < NUM_CH; k++) begin
				acc_q[k] <= '0;
			end
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						ch_q    <= '0;
						state_q <= pop_frame.skip ? ST_ERR : ST_MAG;
					end
				end
				ST_MAG: begin
					state_q <= ST_SQR;
				end
				ST_SQR: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					acc_q[ch_q] <= acc_q[ch_q] + ACC_W'(sq_q);
					if (ch_last) begin
						state_q <= ST_FCNT;
					end else begin
						ch_q    <= ch_q + 1'b1;
						state_q <= ST_MAG;
					end
				end
				ST_FCNT: begin
					if (cnt_inc >= per_eff) begin
						fcnt_q  <= '0;
						div_q   <= per_eff;
						ch_q    <= '0;
						state_q <= ST_LOAD;
					end else begin
						fcnt_q  <= cnt_inc;
						state_q <= ST_IDLE;
					end
				end
				ST_LOAD: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (step_q == STEP_W'(ACC_W - 1)) begin
						step_q  <= '0;
						state_q <= ST_SQRT;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_SQRT: begin
					if (step_q == STEP_W'(ROOT_W - 1)) begin
						state_q <= ST_OUT;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						acc_q[ch_q] <= '0;
						if (ch_last) begin
							state_q <= ST_IDLE;
						end else begin
							ch_q    <= ch_q + 1'b1;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_ERR: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`FCRMS_ASSERT(a_last_on_final, (out_valid_q && out_q.last) |-> (out_q.frame_error || out_q.channel == CH_W'(NUM_CH - 1)), "last flag on a result that is not final")
	`FCRMS_ASSERT(a_error_payload, (out_valid_q && out_q.frame_error) |-> (out_q.square_sum == '0 && out_q.rms_code == '0 && out_q.last), "error result with nonzero payload")
	`FCRMS_ASSERT_NEXT(a_period_restart, (state_q == ST_FCNT && cnt_inc >= per_eff), (fcnt_q == '0 && state_q == ST_LOAD && ch_q == '0), "period end did not restart the frame count")
endmodule
`default_nettype wire

// ===== sv/four_channel_rms_accumulator_unit.sv =====
// channel   signals                                         direction
// input     in_valid, in_ready, sample, skip_frame          request in
// output    out_valid, out_ready, channel, square_sum,
//           rms_code, frame_error, last                     request out
// config    cfg_we, cfg_index, cfg_data                     write only
//
// the front takes one sample per cycle while in_ready is high and pushes a frame record on each frame's last word
// the back handles a good frame as pop, then mean, square and add per channel, then count,
// and a discard as pop, then an error result
// a period end runs load, a 32-step divide, a 16-step root and output for each channel
// the two-entry frame queue stalls in_ready only on a last word while it is full
// reset clears sample index, frame sums, accumulators and frame count; period resets to 24
`default_nettype none
module four_channel_rms_accumulator_unit (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [fcrms_pkg::SAMPLE_W-1:0]       sample,
	input  wire logic                                 skip_frame,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic [fcrms_pkg::CH_W-1:0]                channel,
	output logic [fcrms_pkg::ACC_W-1:0]               square_sum,
	output logic [fcrms_pkg::RMS_W-1:0]               rms_code,
	output logic                                      frame_error,
	output logic                                      last,
	input  wire logic                                 cfg_we,
	input  wire logic [fcrms_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [fcrms_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import fcrms_pkg::*;

	logic [PER_W-1:0]              period_q;
	logic [NUM_CH-1:0][OFF_W-1:0]  offsets_q;
	logic                          push;
	frame_t                        push_frame;
	logic                          pop;
	frame_t                        pop_frame;
	queue_stat_t                   q_stat;
	result_t                       res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q  <= PERIOD_RESET;
			offsets_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PERIOD:   period_q     <= cfg_data[PER_W-1:0];
				REG_OFFSET_A: offsets_q[0] <= cfg_data[OFF_W-1:0];
				REG_OFFSET_B: offsets_q[1] <= cfg_data[OFF_W-1:0];
				REG_OFFSET_C: offsets_q[2] <= cfg_data[OFF_W-1:0];
				REG_OFFSET_D: offsets_q[3] <= cfg_data[OFF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	fcrms_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample     (sample),
		.skip_frame (skip_frame),
		.push       (push),
		.push_frame (push_frame),
		.q_stat     (q_stat)
	);

	fcrms_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_frame (push_frame),
		.pop        (pop),
		.pop_frame  (pop_frame),
		.q_stat     (q_stat)
	);

	fcrms_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.pop_frame  (pop_frame),
		.pop        (pop),
		.period     (period_q),
		.offsets    (offsets_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_result (res)
	);

	assign channel     = res.channel;
	assign square_sum  = res.square_sum;
	assign rms_code    = res.rms_code;
	assign frame_error = res.frame_error;
	assign last        = res.last;
endmodule
`default_nettype wire

// ===== tb/four_channel_rms_accumulator_unit_test.sv =====
`default_nettype none
module four_channel_rms_accumulator_unit_test;
	import fcrms_pkg::*;

	localparam int RUN_LIMIT    = 400000;
	localparam int DRAIN_WAIT   = 400;
	localparam int HOLD_LEN     = 500;
	localparam int IDLE_PCT     = 9;
	localparam int SHOW_MAX     = 10;
	localparam int RANDOM_ITEMS = 64;

	typedef enum int {FILL_RANDOM, FILL_MAX, FILL_ZERO, FILL_SPLIT} fill_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                skip;
	} sample_req_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [SAMPLE_W-1:0]   sample = '0;
	logic                  skip_frame = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [CH_W-1:0]       channel;
	logic [ACC_W-1:0]      square_sum;
	logic [RMS_W-1:0]      rms_code;
	logic                  frame_error;
	logic                  last;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	four_channel_rms_accumulator_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .sample(sample), .skip_frame(skip_frame),
		.out_valid(out_valid), .out_ready(out_ready), .channel(channel),
		.square_sum(square_sum), .rms_code(rms_code), .frame_error(frame_error), .last(last),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// predicted block state
	logic [PER_W-1:0]  cfg_period = PERIOD_RESET;
	logic [OFF_W-1:0]  cfg_offset [NUM_CH] = '{default: '0};
	logic [IDX_W-1:0]  word_idx = '0;
	logic [SUM_W-1:0]  ch_sum [NUM_CH] = '{default: '0};
	logic [ACC_W-1:0]  sq_acc [NUM_CH] = '{default: '0};
	logic [PER_W-1:0]  frames_done = '0;

	sample_req_t sample_backlog [$];
	result_t     rms_results_due [$];

	logic in_fire = 1'b0;
	int   items_taken = 0;
	int   results_seen = 0;
	int   fail_count = 0;
	int   shown = 0;
	int   cycle_count = 0;
	int   hold_at_item = -1;
	int   hold_left = 0;
	bit   hold_done = 1'b0;
	wire  calm = items_taken >= 128 && items_taken < 288;

	function automatic logic [ROOT_W-1:0] int_root(input logic [ACC_W-1:0] v);
		logic [ROOT_W-1:0] r;
		logic [ROOT_W-1:0] cand;
		logic [63:0]       sq;
		r = '0;
		for (int b = ROOT_W - 1; b >= 0; b--) begin
			cand = r | (ROOT_W'(1) << b);
			sq = 64'(cand) * 64'(cand);
			if (sq <= 64'(v))
				r = cand;
		end
		return r;
	endfunction

	task automatic absorb_sample(input logic [SAMPLE_W-1:0] s, input logic skip);
		logic [CH_W-1:0]   ch;
		logic [MEAN_W-1:0] mean;
		int                diff;
		logic [PER_W-1:0]  per;
		logic [ROOT_W-1:0] root;
		result_t           r;
		ch = word_idx[CH_W-1:0];
		ch_sum[ch] = ch_sum[ch] + SUM_W'(s);
		if (word_idx != IDX_W'(FRAME_WORDS - 1)) begin
			word_idx = word_idx + 1'b1;
			return;
		end
		word_idx = '0;
		if (skip) begin
			for (int k = 0; k < NUM_CH; k++)
				ch_sum[k] = '0;
			r = '0;
			r.frame_error = 1'b1;
			r.last = 1'b1;
			rms_results_due.push_back(r);
			return;
		end
		for (int k = 0; k < NUM_CH; k++) begin
			mean = MEAN_W'(ch_sum[k] >> MEAN_SHIFT);
			diff = int'(mean) - int'(cfg_offset[k]);
			if (diff < 0)
				diff = -diff;
			sq_acc[k] = sq_acc[k] + ACC_W'(diff * diff);
			ch_sum[k] = '0;
		end
		frames_done = frames_done + 1'b1;
		per = (cfg_period == '0) ? PER_W'(1) : cfg_period;
		if (frames_done < per)
			return;
		for (int k = 0; k < NUM_CH; k++) begin
			root = int_root(sq_acc[k] / ACC_W'(per));
			r.channel = CH_W'(k);
			r.square_sum = sq_acc[k];
			r.rms_code = (root > ROOT_W'(RMS_MAX)) ? RMS_MAX : root[RMS_W-1:0];
			r.frame_error = 1'b0;
			r.last = (k == NUM_CH - 1);
			rms_results_due.push_back(r);
			sq_acc[k] = '0;
		end
		frames_done = '0;
	endtask

	// request acceptance and result checking
	always @(posedge clk) begin
		result_t got;
		result_t want;
		in_fire = in_valid && in_ready;
		if (in_fire) begin
			absorb_sample(sample, skip_frame);
			items_taken++;
		end
		if (out_valid === 1'b1 && out_ready) begin
			got.channel = channel;
			got.square_sum = square_sum;
			got.rms_code = rms_code;
			got.frame_error = frame_error;
			got.last = last;
			results_seen++;
			if (rms_results_due.size() == 0) begin
				fail_count++;
				if (shown < SHOW_MAX) begin
					shown++;
					$display("unexpected result: ch %0d sum %0d rms %0d err %b last %b",
						got.channel, got.square_sum, got.rms_code, got.frame_error, got.last);
				end
			end else begin
				want = rms_results_due.pop_front();
				if (got.channel !== want.channel || got.square_sum !== want.square_sum ||
						got.rms_code !== want.rms_code || got.frame_error !== want.frame_error ||
						got.last !== want.last) begin
					fail_count++;
					if (shown < SHOW_MAX) begin
						shown++;
						$display("mismatch: exp ch %0d sum %0d rms %0d err %b last %b",
							want.channel, want.square_sum, want.rms_code, want.frame_error,
							want.last);
						$display("          got ch %0d sum %0d rms %0d err %b last %b",
							got.channel, got.square_sum, got.rms_code, got.frame_error, got.last);
					end
				end
			end
		end
	end

	// sample driver
	always @(negedge clk) begin
		sample_req_t next_req;
		if (arst_n && (!in_valid || in_fire)) begin
			if (sample_backlog.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
				next_req = sample_backlog.pop_front();
				sample <= next_req.sample;
				skip_frame <= next_req.skip;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!hold_done && hold_at_item >= 0 && items_taken >= hold_at_item) begin
				hold_done = 1'b1;
				hold_left = HOLD_LEN;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm || $urandom_range(99) >= IDLE_PCT;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > RUN_LIMIT) begin
			$display("four_channel_rms_accumulator_unit_test: done, errors");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_PERIOD: cfg_period = data[PER_W-1:0];
			REG_OFFSET_A, REG_OFFSET_B, REG_OFFSET_C, REG_OFFSET_D:
				cfg_offset[idx - REG_OFFSET_A] = data[OFF_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_frame(input fill_t fill, input bit drop, input bit mid_skip);
		sample_req_t req;
		int          pick;
		for (int w = 0; w < FRAME_WORDS; w++) begin
			case (fill)
				FILL_MAX:   req.sample = '1;
				FILL_ZERO:  req.sample = '0;
				FILL_SPLIT: req.sample = (w % 2 == 0) ? '1 : '0;
				default: begin
					pick = $urandom_range(15);
					if (pick == 0)
						req.sample = '0;
					else if (pick == 1)
						req.sample = '1;
					else
						req.sample = SAMPLE_W'($urandom_range(4095));
				end
			endcase
			if (w == FRAME_WORDS - 1)
				req.skip = drop;
			else
				req.skip = mid_skip ? 1'b1 : ($urandom_range(7) == 0);
			sample_backlog.push_back(req);
		end
	endtask

	task automatic drain();
		while (sample_backlog.size() != 0 || in_valid || rms_results_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_offset();
		case ($urandom_range(3))
			0: return '0;
			1: return CFG_DATA_W'(4095);
			default: return CFG_DATA_W'($urandom_range(4095));
		endcase
	endfunction

	initial begin
		int random_items;
		int per;
		int frames;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// full scale, zero, discarded and split frames at one frame per period
		write_reg(REG_PERIOD, CFG_DATA_W'(1));
		write_reg(REG_OFFSET_A, CFG_DATA_W'(0));
		write_reg(REG_OFFSET_B, CFG_DATA_W'(4095));
		write_reg(REG_OFFSET_C, CFG_DATA_W'(2048));
		write_reg(REG_OFFSET_D, CFG_DATA_W'(0));
		push_frame(FILL_MAX, 1'b0, 1'b1);
		push_frame(FILL_ZERO, 1'b0, 1'b0);
		push_frame(FILL_RANDOM, 1'b1, 1'b0);
		push_frame(FILL_SPLIT, 1'b0, 1'b0);
		drain();

		// zero period acts as one
		write_reg(REG_PERIOD, CFG_DATA_W'(0));
		write_reg(REG_OFFSET_A, CFG_DATA_W'(4095));
		write_reg(REG_OFFSET_D, CFG_DATA_W'(4095));
		push_frame(FILL_MAX, 1'b0, 1'b0);
		push_frame(FILL_RANDOM, 1'b0, 1'b0);
		drain();

		// longest period, then lowered to the number of frames already summed
		write_reg(REG_PERIOD, CFG_DATA_W'(255));
		write_reg(REG_OFFSET_A, CFG_DATA_W'(0));
		write_reg(REG_OFFSET_B, CFG_DATA_W'(0));
		write_reg(REG_OFFSET_C, CFG_DATA_W'(0));
		write_reg(REG_OFFSET_D, CFG_DATA_W'(0));
		push_frame(FILL_MAX, 1'b0, 1'b0);
		push_frame(FILL_MAX, 1'b0, 1'b0);
		drain();
		write_reg(REG_PERIOD, CFG_DATA_W'(2));
		push_frame(FILL_MAX, 1'b0, 1'b0);
		drain();

		// receiver stalls while frames keep coming
		write_reg(REG_PERIOD, CFG_DATA_W'(1));
		hold_at_item = items_taken + 40;
		for (int f = 0; f < 4; f++)
			push_frame(FILL_RANDOM, 1'b0, 1'b0);
		drain();

		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			case ($urandom_range(9))
				0: per = 0;
				1: per = 1;
				default: per = $urandom_range(1, 4);
			endcase
			write_reg(REG_PERIOD, CFG_DATA_W'(per));
			if ($urandom_range(1)) write_reg(REG_OFFSET_A, pick_offset());
			if ($urandom_range(1)) write_reg(REG_OFFSET_B, pick_offset());
			if ($urandom_range(1)) write_reg(REG_OFFSET_C, pick_offset());
			if ($urandom_range(1)) write_reg(REG_OFFSET_D, pick_offset());
			frames = $urandom_range(1, 2);
			for (int f = 0; f < frames; f++) begin
				push_frame(($urandom_range(7) == 0) ? FILL_MAX : FILL_RANDOM,
					$urandom_range(9) == 0, 1'b0);
				random_items += FRAME_WORDS;
			end
			drain();
		end

		drain();
		if (rms_results_due.size() != 0)
			fail_count++;
		if (fail_count == 0)
			$display("four_channel_rms_accumulator_unit_test: done, clean");
		else
			$display("four_channel_rms_accumulator_unit_test: done, errors");
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+sv
sv/fcrms_pkg.sv
sv/fcrms_front.sv
sv/fcrms_queue.sv
sv/fcrms_back.sv
sv/four_channel_rms_accumulator_unit.sv
tb/four_channel_rms_accumulator_unit_test.sv
